@@ sv/slsc_pkg.sv @@
`timescale 1ns / 1ps
package slsc_pkg;

  localparam logic [20:0] CP_TAB       = 21'h00009;
  localparam logic [20:0] CP_NEWLINE   = 21'h0000A;
  localparam logic [20:0] CP_RETURN    = 21'h0000D;
  localparam logic [20:0] CP_SPACE     = 21'h00020;
  localparam logic [20:0] CP_QUOTE     = 21'h00022;
  localparam logic [20:0] CP_PERCENT   = 21'h00025;
  localparam logic [20:0] CP_LPAREN    = 21'h00028;
  localparam logic [20:0] CP_RPAREN    = 21'h00029;
  localparam logic [20:0] CP_COMMA     = 21'h0002C;
  localparam logic [20:0] CP_DOT       = 21'h0002E;
  localparam logic [20:0] CP_SLASH     = 21'h0002F;
  localparam logic [20:0] CP_DIGIT_0   = 21'h00030;
  localparam logic [20:0] CP_DIGIT_9   = 21'h00039;
  localparam logic [20:0] CP_COLON     = 21'h0003A;
  localparam logic [20:0] CP_SEMICOLON = 21'h0003B;
  localparam logic [20:0] CP_LESS      = 21'h0003C;
  localparam logic [20:0] CP_GREATER   = 21'h0003E;
  localparam logic [20:0] CP_UPPER_A   = 21'h00041;
  localparam logic [20:0] CP_UPPER_Z   = 21'h0005A;
  localparam logic [20:0] CP_UNDERLINE = 21'h0005F;
  localparam logic [20:0] CP_LOWER_A   = 21'h00061;
  localparam logic [20:0] CP_LOWER_Z   = 21'h0007A;
  localparam logic [20:0] CP_A_RING_LC = 21'h000E5;
  localparam logic [20:0] CP_A_UML_LC  = 21'h000E4;
  localparam logic [20:0] CP_O_UML_LC  = 21'h000F6;
  localparam logic [20:0] CP_A_RING_UC = 21'h000C5;
  localparam logic [20:0] CP_A_UML_UC  = 21'h000C4;
  localparam logic [20:0] CP_O_UML_UC  = 21'h000D6;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    SCAN_IDLE      = 3'd0,
    SCAN_IDENT     = 3'd1,
    SCAN_NUMBER    = 3'd2,
    SCAN_STRING    = 3'd3,
    SCAN_SLASH     = 3'd4,
    SCAN_LINE      = 3'd5,
    SCAN_BLOCK     = 3'd6,
    SCAN_BLOCK_PCT = 3'd7
  } scan_mode_t;

  typedef enum logic [1:0] {
    KIND_IDENT  = 2'd0,
    KIND_NUMBER = 2'd1,
    KIND_STRING = 2'd2,
    KIND_DELIM  = 2'd3
  } lex_kind_t;

  typedef enum logic [1:0] {
    PH_PRE  = 2'd0,
    PH_BYTE = 2'd1,
    PH_POST = 2'd2
  } phase_t;

  // Work for one character: an optional end of the previous lexeme, up to four
  // bytes of the current one and an optional end of the current one.
  typedef struct packed {
    logic         pre_valid;
    lex_kind_t    pre_kind;
    logic [6:0]   pre_length;
    logic         pre_truncated;
    logic [15:0]  pre_line;
    logic [15:0]  pre_column;
    lex_kind_t    kind;
    logic [2:0]   byte_total;
    logic [31:0]  utf8_bytes;
    logic         post_valid;
    logic [6:0]   post_length;
    logic         post_truncated;
    logic [15:0]  line;
    logic [15:0]  column;
  } job_t;

  typedef struct packed {
    lex_kind_t    kind;
    logic         is_end;
    logic [7:0]   data_byte;
    logic [6:0]   length;
    logic         truncated;
    logic [15:0]  line;
    logic [15:0]  column;
    logic         run_last;
  } result_t;

  function automatic logic decimal_digit(logic [20:0] cp);
    return (cp >= CP_DIGIT_0) && (cp <= CP_DIGIT_9);
  endfunction

  function automatic logic name_letter(logic [20:0] cp);
    return ((cp >= CP_LOWER_A) && (cp <= CP_LOWER_Z)) ||
           ((cp >= CP_UPPER_A) && (cp <= CP_UPPER_Z)) ||
           (cp == CP_A_RING_LC) || (cp == CP_A_UML_LC) || (cp == CP_O_UML_LC) ||
           (cp == CP_A_RING_UC) || (cp == CP_A_UML_UC) || (cp == CP_O_UML_UC);
  endfunction

  function automatic logic is_delim(logic [20:0] cp);
    return (cp == CP_LPAREN) || (cp == CP_RPAREN) || (cp == CP_LESS) ||
           (cp == CP_GREATER) || (cp == CP_SEMICOLON) || (cp == CP_COMMA) ||
           (cp == CP_COLON);
  endfunction

endpackage

@@ sv/slsc_if.sv @@
`timescale 1ns / 1ps
interface slsc_char_if;
  logic        valid;
  logic        ready;
  logic [20:0] codepoint;
  logic [31:0] utf8_bytes;
  logic [2:0]  byte_count;
  logic        last_char;

  modport source (output valid, codepoint, utf8_bytes, byte_count, last_char, input ready);
  modport sink (input valid, codepoint, utf8_bytes, byte_count, last_char, output ready);
endinterface

interface slsc_lexeme_if;
  logic        valid;
  logic        ready;
  logic [1:0]  lex_kind;
  logic        is_end;
  logic [7:0]  data_byte;
  logic [6:0]  lexeme_length;
  logic        truncated;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic        run_last;

  modport source (output valid, lex_kind, is_end, data_byte, lexeme_length, truncated,
                  start_line, start_column, run_last, input ready);
  modport sink (input valid, lex_kind, is_end, data_byte, lexeme_length, truncated,
                start_line, start_column, run_last, output ready);
endinterface

@@ sv/source_lexeme_scanner_top.sv @@
// Lexeme scanner: takes one decoded character per transaction on chars and
// delivers the lexeme stream on lexemes, one transaction per stored byte and
// one closing transaction per lexeme with its length, truncation flag and start
// position. The scanner front classifies a character combinationally and
// accepts one character per cycle while its four-entry work queue has room.
// The result sequencer delivers one result per cycle while the output is not
// stalled; a character causes up to six results, and skipped characters cause
// nothing at the output. The input therefore keeps up at one character per
// cycle as long as characters average at most one result each. Line and
// column restart at one after the character marked as the last of a text.
`timescale 1ns / 1ps
module source_lexeme_scanner_top #(
  parameter int MAX_LEXEME_BYTES = 128
) (
  input  logic          clk,
  input  logic          rst,
  slsc_char_if.sink     chars,
  slsc_lexeme_if.source lexemes
);

  localparam int StoreLimit = (MAX_LEXEME_BYTES - 1 < 127) ? MAX_LEXEME_BYTES - 1 : 127;

  logic           job_valid;
  slsc_pkg::job_t job;
  logic           queue_full;
  logic           queue_not_empty;
  logic           queue_pop;
  slsc_pkg::job_t queue_head;

  slsc_front #(
    .MAX_LEXEME_BYTES(MAX_LEXEME_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .chars     (chars),
    .queue_full(queue_full),
    .job_valid (job_valid),
    .job       (job)
  );

  slsc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_valid),
    .push_job (job),
    .full     (queue_full),
    .pop      (queue_pop),
    .not_empty(queue_not_empty),
    .head     (queue_head)
  );

  slsc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(queue_not_empty),
    .job      (queue_head),
    .job_pop  (queue_pop),
    .lexemes  (lexemes)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> !queue_full)
    else $error("Work queue written while full.");

  a_byte_fields_clear: assert property (@(posedge clk) disable iff (rst)
    lexemes.valid && !lexemes.is_end |-> lexemes.lexeme_length == 7'd0 && !lexemes.truncated)
    else $error("Byte transaction carries end fields.");

  a_length_limit: assert property (@(posedge clk) disable iff (rst)
    lexemes.valid && lexemes.is_end |-> lexemes.lexeme_length <= 7'(StoreLimit))
    else $error("Lexeme length exceeds the store limit.");

  a_delim_end_last: assert property (@(posedge clk) disable iff (rst)
    lexemes.valid && lexemes.is_end && lexemes.lex_kind == slsc_pkg::KIND_DELIM
      |-> lexemes.run_last)
    else $error("Delimiter end is not the last result of its character.");

endmodule

@@ sv/slsc_front.sv @@
`timescale 1ns / 1ps
module slsc_front #(
  parameter int MAX_LEXEME_BYTES = 128
) (
  input  logic             clk,
  input  logic             rst,
  slsc_char_if.sink        chars,
  input  logic             queue_full,
  output logic             job_valid,
  output slsc_pkg::job_t   job
);

  localparam int StoreLimit = (MAX_LEXEME_BYTES - 1 < 127) ? MAX_LEXEME_BYTES - 1 : 127;

  slsc_pkg::scan_mode_t mode, mode_next;
  logic [15:0] line, line_next;
  logic [15:0] column, column_next;
  logic [15:0] start_line, start_line_next;
  logic [15:0] start_column, start_column_next;
  logic [6:0]  count, count_next;
  logic        has_dot, has_dot_next;
  logic        overflowed, overflowed_next;

  logic        accept;
  logic [20:0] cp;
  logic [2:0]  nb;
  logic        do_idle;
  logic        inc_col;
  logic        inc_line;
  logic        start;
  logic [2:0]  req;
  logic [6:0]  count_base;
  logic        ovf_base;
  logic [6:0]  avail;
  logic [2:0]  n_emit;

  assign chars.ready = !queue_full;
  assign accept      = chars.valid && chars.ready;
  assign cp          = chars.codepoint;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= slsc_pkg::SCAN_IDLE;
      line         <= 16'd1;
      column       <= 16'd1;
      start_line   <= 16'd1;
      start_column <= 16'd1;
      count        <= 7'd0;
      has_dot      <= 1'b0;
      overflowed   <= 1'b0;
    end else if (accept) begin
      mode         <= mode_next;
      line         <= line_next;
      column       <= column_next;
      start_line   <= start_line_next;
      start_column <= start_column_next;
      count        <= count_next;
      has_dot      <= has_dot_next;
      overflowed   <= overflowed_next;
    end
  end

  always_comb begin
    mode_next         = mode;
    line_next         = line;
    column_next       = column;
    start_line_next   = start_line;
    start_column_next = start_column;
    has_dot_next      = has_dot;
    do_idle           = 1'b0;
    inc_col           = 1'b0;
    inc_line          = 1'b0;
    start             = 1'b0;
    req               = 3'd0;
    job               = '0;

    if (chars.byte_count == 3'd0) begin
      nb = 3'd1;
    end else if (chars.byte_count > 3'd4) begin
      nb = 3'd4;
    end else begin
      nb = chars.byte_count;
    end

    unique case (mode) inside
      slsc_pkg::SCAN_IDENT: begin
        if (slsc_pkg::name_letter(cp) || slsc_pkg::decimal_digit(cp) ||
            cp == slsc_pkg::CP_UNDERLINE || cp == slsc_pkg::CP_DOT) begin
          req      = nb;
          job.kind = slsc_pkg::KIND_IDENT;
          inc_col  = 1'b1;
        end else begin
          job.pre_valid = 1'b1;
          job.pre_kind  = slsc_pkg::KIND_IDENT;
          do_idle       = 1'b1;
        end
      end
      slsc_pkg::SCAN_NUMBER: begin
        if ((cp == slsc_pkg::CP_DOT && !has_dot) || slsc_pkg::decimal_digit(cp)) begin
          if (cp == slsc_pkg::CP_DOT) begin
            has_dot_next = 1'b1;
          end
          req      = 3'd1;
          job.kind = slsc_pkg::KIND_NUMBER;
          inc_col  = 1'b1;
        end else begin
          job.pre_valid = 1'b1;
          job.pre_kind  = slsc_pkg::KIND_NUMBER;
          do_idle       = 1'b1;
        end
      end
      slsc_pkg::SCAN_STRING: begin
        inc_col  = 1'b1;
        job.kind = slsc_pkg::KIND_STRING;
        if (cp == slsc_pkg::CP_QUOTE) begin
          job.post_valid = 1'b1;
          mode_next      = slsc_pkg::SCAN_IDLE;
        end else begin
          req = 3'd1;
        end
      end
      slsc_pkg::SCAN_SLASH: begin
        if (cp == slsc_pkg::CP_SLASH) begin
          mode_next = slsc_pkg::SCAN_LINE;
          inc_col   = 1'b1;
        end else if (cp == slsc_pkg::CP_PERCENT) begin
          mode_next = slsc_pkg::SCAN_BLOCK;
          inc_col   = 1'b1;
        end else begin
          do_idle = 1'b1;
        end
      end
      slsc_pkg::SCAN_LINE: begin
        if (cp == slsc_pkg::CP_NEWLINE) begin
          mode_next = slsc_pkg::SCAN_IDLE;
          inc_line  = 1'b1;
        end else begin
          inc_col = 1'b1;
        end
      end
      slsc_pkg::SCAN_BLOCK, slsc_pkg::SCAN_BLOCK_PCT: begin
        if (mode == slsc_pkg::SCAN_BLOCK_PCT && cp == slsc_pkg::CP_SLASH) begin
          mode_next = slsc_pkg::SCAN_IDLE;
          inc_col   = 1'b1;
        end else if (chars.last_char) begin
          do_idle = 1'b1;
        end else if (cp == slsc_pkg::CP_NEWLINE) begin
          mode_next = slsc_pkg::SCAN_BLOCK;
          inc_line  = 1'b1;
        end else begin
          mode_next = (cp == slsc_pkg::CP_PERCENT) ? slsc_pkg::SCAN_BLOCK_PCT
                                                   : slsc_pkg::SCAN_BLOCK;
          inc_col   = 1'b1;
        end
      end
      default: begin
        do_idle = 1'b1;
      end
    endcase

    if (do_idle) begin
      mode_next = slsc_pkg::SCAN_IDLE;
      if (cp == slsc_pkg::CP_NEWLINE) begin
        inc_line = 1'b1;
      end else begin
        inc_col = 1'b1;
        if (cp == slsc_pkg::CP_SLASH) begin
          if (!chars.last_char) begin
            mode_next = slsc_pkg::SCAN_SLASH;
          end
        end else if (cp == slsc_pkg::CP_QUOTE) begin
          start     = 1'b1;
          mode_next = slsc_pkg::SCAN_STRING;
        end else if (slsc_pkg::name_letter(cp)) begin
          start     = 1'b1;
          mode_next = slsc_pkg::SCAN_IDENT;
          req       = nb;
          job.kind  = slsc_pkg::KIND_IDENT;
        end else if (slsc_pkg::decimal_digit(cp)) begin
          start     = 1'b1;
          mode_next = slsc_pkg::SCAN_NUMBER;
          req       = 3'd1;
          job.kind  = slsc_pkg::KIND_NUMBER;
        end else if (slsc_pkg::is_delim(cp)) begin
          start          = 1'b1;
          req            = 3'd1;
          job.kind       = slsc_pkg::KIND_DELIM;
          job.post_valid = 1'b1;
        end
      end
    end

    if (start) begin
      start_line_next   = line;
      start_column_next = column;
      has_dot_next      = 1'b0;
    end
    count_base = start ? 7'd0 : count;
    ovf_base   = start ? 1'b0 : overflowed;

    avail = 7'(StoreLimit) - count_base;
    if ({4'd0, req} > avail) begin
      n_emit          = avail[2:0];
      overflowed_next = 1'b1;
    end else begin
      n_emit          = req;
      overflowed_next = ovf_base;
    end
    count_next = count_base + {4'd0, n_emit};

    if (inc_line) begin
      line_next   = (line != 16'hFFFF) ? line + 16'd1 : line;
      column_next = 16'd1;
    end else if (inc_col) begin
      column_next = (column != 16'hFFFF) ? column + 16'd1 : column;
    end

    if (chars.last_char) begin
      if (mode_next == slsc_pkg::SCAN_IDENT) begin
        job.post_valid = 1'b1;
        job.kind       = slsc_pkg::KIND_IDENT;
      end else if (mode_next == slsc_pkg::SCAN_NUMBER) begin
        job.post_valid = 1'b1;
        job.kind       = slsc_pkg::KIND_NUMBER;
      end else if (mode_next == slsc_pkg::SCAN_STRING) begin
        job.post_valid = 1'b1;
        job.kind       = slsc_pkg::KIND_STRING;
      end
      mode_next   = slsc_pkg::SCAN_IDLE;
      line_next   = 16'd1;
      column_next = 16'd1;
    end

    job.pre_length     = count;
    job.pre_truncated  = overflowed;
    job.pre_line       = start_line;
    job.pre_column     = start_column;
    job.byte_total     = n_emit;
    job.utf8_bytes     = chars.utf8_bytes;
    job.post_length    = count_next;
    job.post_truncated = overflowed_next;
    job.line           = start_line_next;
    job.column         = start_column_next;
  end

  assign job_valid = accept && (job.pre_valid || job.post_valid || (n_emit != 3'd0));

endmodule

@@ sv/slsc_queue.sv @@
`timescale 1ns / 1ps
module slsc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  slsc_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output slsc_pkg::job_t head
);

  localparam int PtrW = $clog2(slsc_pkg::QUEUE_DEPTH);
  localparam int CntW = $clog2(slsc_pkg::QUEUE_DEPTH + 1);

  slsc_pkg::job_t entries [slsc_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;

  assign full      = (fill == CntW'(slsc_pkg::QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CntW'(1);
      end else if (pop && !push) begin
        fill <= fill - CntW'(1);
      end
    end
  end

endmodule

@@ sv/slsc_back.sv @@
`timescale 1ns / 1ps
module slsc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  input  slsc_pkg::job_t job,
  output logic           job_pop,
  slsc_lexeme_if.source  lexemes
);

  slsc_pkg::phase_t  phase, phase_next;
  logic              cur_valid, cur_valid_next;
  logic [1:0]        byte_index, byte_index_next;
  slsc_pkg::job_t    cur;
  slsc_pkg::result_t res;
  slsc_pkg::result_t out_q;
  logic              out_valid;
  logic              emit;
  logic              load;
  slsc_pkg::phase_t  after_pre;
  slsc_pkg::phase_t  first_phase;
  logic [2:0]        next_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= slsc_pkg::PH_PRE;
      cur_valid  <= 1'b0;
      byte_index <= 2'd0;
    end else begin
      phase      <= phase_next;
      cur_valid  <= cur_valid_next;
      byte_index <= byte_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= job;
    end
  end

  always_comb begin
    emit       = cur_valid && (!out_valid || lexemes.ready);
    next_index = {1'b0, byte_index} + 3'd1;
    after_pre  = (cur.byte_total != 3'd0) ? slsc_pkg::PH_BYTE : slsc_pkg::PH_POST;

    res        = '0;
    res.kind   = cur.kind;
    res.line   = cur.line;
    res.column = cur.column;
    phase_next = phase;

    unique case (phase)
      slsc_pkg::PH_PRE: begin
        res.kind      = cur.pre_kind;
        res.is_end    = 1'b1;
        res.length    = cur.pre_length;
        res.truncated = cur.pre_truncated;
        res.line      = cur.pre_line;
        res.column    = cur.pre_column;
        res.run_last  = (cur.byte_total == 3'd0) && !cur.post_valid;
        phase_next    = after_pre;
      end
      slsc_pkg::PH_BYTE: begin
        res.data_byte = cur.utf8_bytes[{byte_index, 3'b000} +: 8];
        res.run_last  = (next_index >= cur.byte_total) && !cur.post_valid;
        phase_next    = (next_index >= cur.byte_total) ? slsc_pkg::PH_POST
                                                       : slsc_pkg::PH_BYTE;
      end
      slsc_pkg::PH_POST: begin
        res.is_end    = 1'b1;
        res.length    = cur.post_length;
        res.truncated = cur.post_truncated;
        res.run_last  = 1'b1;
      end
      default: begin
        res.run_last = 1'b1;
      end
    endcase

    if (job.pre_valid) begin
      first_phase = slsc_pkg::PH_PRE;
    end else if (job.byte_total != 3'd0) begin
      first_phase = slsc_pkg::PH_BYTE;
    end else begin
      first_phase = slsc_pkg::PH_POST;
    end

    load            = job_valid && (!cur_valid || (emit && res.run_last));
    cur_valid_next  = cur_valid;
    byte_index_next = byte_index;

    if (load) begin
      cur_valid_next  = 1'b1;
      phase_next      = first_phase;
      byte_index_next = 2'd0;
    end else if (emit && res.run_last) begin
      cur_valid_next = 1'b0;
    end else if (emit) begin
      if (phase == slsc_pkg::PH_BYTE) begin
        byte_index_next = next_index[1:0];
      end
    end else begin
      phase_next = phase;
    end
  end

  assign job_pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (lexemes.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_q <= res;
    end
  end

  assign lexemes.valid         = out_valid;
  assign lexemes.lex_kind      = out_q.kind;
  assign lexemes.is_end        = out_q.is_end;
  assign lexemes.data_byte     = out_q.data_byte;
  assign lexemes.lexeme_length = out_q.length;
  assign lexemes.truncated     = out_q.truncated;
  assign lexemes.start_line    = out_q.line;
  assign lexemes.start_column  = out_q.column;
  assign lexemes.run_last      = out_q.run_last;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;

  localparam int MAX_LEXEME = 128;
  localparam int STORE_LIMIT = (MAX_LEXEME - 1 < 127) ? MAX_LEXEME - 1 : 127;
  localparam int IDLE_LIMIT = 5000;
  localparam int ITEM_TARGET = 400;

  typedef struct {
    logic [20:0] cp;
    logic [31:0] bytes;
    logic [2:0]  count;
    logic        last;
    bit          no_gap;
    bit          drain;
  } char_item_t;

  logic clk = 1'b0;
  logic rst;

  slsc_char_if chars();
  slsc_lexeme_if lexemes();

  source_lexeme_scanner_top #(
    .MAX_LEXEME_BYTES(MAX_LEXEME)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .chars(chars),
    .lexemes(lexemes)
  );

  always #2 clk = ~clk;

  char_item_t        char_queue[$];
  char_item_t        driven;
  slsc_pkg::result_t lexeme_expect[$];
  slsc_pkg::result_t char_results[$];
  slsc_pkg::result_t seen;
  slsc_pkg::result_t wanted;
  bit                text_calm;
  int                gap_left;
  int                stall_left;
  int                calm_left;
  int                idle_cycles;
  int                mismatch_count;

  slsc_pkg::scan_mode_t mode;
  logic [15:0]          line_no;
  logic [15:0]          col_no;
  logic [15:0]          lex_line;
  logic [15:0]          lex_col;
  int                   stored;
  logic                 has_dot;
  logic                 overflowed;

  function automatic bit letter_cp(logic [20:0] cp);
    return (cp >= slsc_pkg::CP_LOWER_A && cp <= slsc_pkg::CP_LOWER_Z) ||
           (cp >= slsc_pkg::CP_UPPER_A && cp <= slsc_pkg::CP_UPPER_Z) ||
           cp == slsc_pkg::CP_A_RING_LC || cp == slsc_pkg::CP_A_UML_LC ||
           cp == slsc_pkg::CP_O_UML_LC || cp == slsc_pkg::CP_A_RING_UC ||
           cp == slsc_pkg::CP_A_UML_UC || cp == slsc_pkg::CP_O_UML_UC;
  endfunction

  function automatic bit digit_cp(logic [20:0] cp);
    return cp >= slsc_pkg::CP_DIGIT_0 && cp <= slsc_pkg::CP_DIGIT_9;
  endfunction

  function automatic bit delim_cp(logic [20:0] cp);
    return cp == slsc_pkg::CP_LPAREN || cp == slsc_pkg::CP_RPAREN ||
           cp == slsc_pkg::CP_LESS || cp == slsc_pkg::CP_GREATER ||
           cp == slsc_pkg::CP_SEMICOLON || cp == slsc_pkg::CP_COMMA ||
           cp == slsc_pkg::CP_COLON;
  endfunction

  function automatic void emit(slsc_pkg::lex_kind_t k, logic e, logic [7:0] b,
                               logic [6:0] len, logic tr);
    slsc_pkg::result_t r;
    r.kind = k;
    r.is_end = e;
    r.data_byte = b;
    r.length = len;
    r.truncated = tr;
    r.line = lex_line;
    r.column = lex_col;
    r.run_last = 1'b0;
    char_results.push_back(r);
  endfunction

  function automatic void advance_column();
    if (col_no != 16'hFFFF) col_no++;
  endfunction

  function automatic void advance_line();
    if (line_no != 16'hFFFF) line_no++;
    col_no = 16'd1;
  endfunction

  function automatic void open_lexeme(slsc_pkg::scan_mode_t m);
    mode = m;
    lex_line = line_no;
    lex_col = col_no;
    stored = 0;
    has_dot = 1'b0;
    overflowed = 1'b0;
  endfunction

  function automatic void store_lexeme_byte(slsc_pkg::lex_kind_t k, logic [7:0] b);
    if (stored < STORE_LIMIT) begin
      emit(k, 1'b0, b, 7'd0, 1'b0);
      stored++;
    end else begin
      overflowed = 1'b1;
    end
  endfunction

  function automatic void store_all_bytes(logic [31:0] bytes, int nb);
    for (int i = 0; i < nb; i++) store_lexeme_byte(slsc_pkg::KIND_IDENT, bytes[8*i +: 8]);
  endfunction

  function automatic void close_lexeme(slsc_pkg::lex_kind_t k);
    emit(k, 1'b1, 8'd0, 7'(stored), overflowed);
    mode = slsc_pkg::SCAN_IDLE;
  endfunction

  function automatic void scan_fresh(logic [20:0] cp, logic [31:0] bytes, int nb, logic last);
    mode = slsc_pkg::SCAN_IDLE;
    if (cp == slsc_pkg::CP_NEWLINE) begin
      advance_line();
    end else if (cp == slsc_pkg::CP_SPACE || cp == slsc_pkg::CP_TAB ||
                 cp == slsc_pkg::CP_RETURN) begin
      advance_column();
    end else if (cp == slsc_pkg::CP_SLASH) begin
      if (!last) mode = slsc_pkg::SCAN_SLASH;
      advance_column();
    end else if (cp == slsc_pkg::CP_QUOTE) begin
      open_lexeme(slsc_pkg::SCAN_STRING);
      advance_column();
    end else if (letter_cp(cp)) begin
      open_lexeme(slsc_pkg::SCAN_IDENT);
      store_all_bytes(bytes, nb);
      advance_column();
    end else if (digit_cp(cp)) begin
      open_lexeme(slsc_pkg::SCAN_NUMBER);
      store_lexeme_byte(slsc_pkg::KIND_NUMBER, bytes[7:0]);
      advance_column();
    end else if (delim_cp(cp)) begin
      open_lexeme(slsc_pkg::SCAN_IDLE);
      store_lexeme_byte(slsc_pkg::KIND_DELIM, bytes[7:0]);
      close_lexeme(slsc_pkg::KIND_DELIM);
      advance_column();
    end else begin
      advance_column();
    end
  endfunction

  // Works out the results of one accepted character and queues them.
  function automatic void scan_char(logic [20:0] cp, logic [31:0] bytes, logic [2:0] count,
                                    logic last);
    int                nb;
    slsc_pkg::result_t r;
    nb = (count == 3'd0) ? 1 : (count > 3'd4) ? 4 : int'(count);
    char_results.delete();
    case (mode)
      slsc_pkg::SCAN_IDENT: begin
        if (letter_cp(cp) || digit_cp(cp) || cp == slsc_pkg::CP_UNDERLINE ||
            cp == slsc_pkg::CP_DOT) begin
          store_all_bytes(bytes, nb);
          advance_column();
        end else begin
          close_lexeme(slsc_pkg::KIND_IDENT);
          scan_fresh(cp, bytes, nb, last);
        end
      end
      slsc_pkg::SCAN_NUMBER: begin
        if (cp == slsc_pkg::CP_DOT && !has_dot) begin
          has_dot = 1'b1;
          store_lexeme_byte(slsc_pkg::KIND_NUMBER, bytes[7:0]);
          advance_column();
        end else if (digit_cp(cp)) begin
          store_lexeme_byte(slsc_pkg::KIND_NUMBER, bytes[7:0]);
          advance_column();
        end else begin
          close_lexeme(slsc_pkg::KIND_NUMBER);
          scan_fresh(cp, bytes, nb, last);
        end
      end
      slsc_pkg::SCAN_STRING: begin
        advance_column();
        if (cp == slsc_pkg::CP_QUOTE) close_lexeme(slsc_pkg::KIND_STRING);
        else store_lexeme_byte(slsc_pkg::KIND_STRING, bytes[7:0]);
      end
      slsc_pkg::SCAN_SLASH: begin
        if (cp == slsc_pkg::CP_SLASH) begin
          mode = slsc_pkg::SCAN_LINE;
          advance_column();
        end else if (cp == slsc_pkg::CP_PERCENT) begin
          mode = slsc_pkg::SCAN_BLOCK;
          advance_column();
        end else begin
          scan_fresh(cp, bytes, nb, last);
        end
      end
      slsc_pkg::SCAN_LINE: begin
        if (cp == slsc_pkg::CP_NEWLINE) begin
          mode = slsc_pkg::SCAN_IDLE;
          advance_line();
        end else begin
          advance_column();
        end
      end
      slsc_pkg::SCAN_BLOCK, slsc_pkg::SCAN_BLOCK_PCT: begin
        if (mode == slsc_pkg::SCAN_BLOCK_PCT && cp == slsc_pkg::CP_SLASH) begin
          mode = slsc_pkg::SCAN_IDLE;
          advance_column();
        end else if (last) begin
          scan_fresh(cp, bytes, nb, last);
        end else if (cp == slsc_pkg::CP_NEWLINE) begin
          mode = slsc_pkg::SCAN_BLOCK;
          advance_line();
        end else begin
          if (cp == slsc_pkg::CP_PERCENT) mode = slsc_pkg::SCAN_BLOCK_PCT;
          else mode = slsc_pkg::SCAN_BLOCK;
          advance_column();
        end
      end
      default: scan_fresh(cp, bytes, nb, last);
    endcase
    if (last) begin
      if (mode == slsc_pkg::SCAN_IDENT) close_lexeme(slsc_pkg::KIND_IDENT);
      else if (mode == slsc_pkg::SCAN_NUMBER) close_lexeme(slsc_pkg::KIND_NUMBER);
      else if (mode == slsc_pkg::SCAN_STRING) close_lexeme(slsc_pkg::KIND_STRING);
      mode = slsc_pkg::SCAN_IDLE;
      line_no = 16'd1;
      col_no = 16'd1;
    end
    if (char_results.size() > 0) begin
      r = char_results.pop_back();
      r.run_last = 1'b1;
      char_results.push_back(r);
    end
    foreach (char_results[i]) lexeme_expect.push_back(char_results[i]);
  endfunction

  function automatic void add_raw(logic [20:0] cp, logic [31:0] bytes, logic [2:0] count);
    char_item_t it;
    it.cp = cp;
    it.bytes = bytes;
    it.count = count;
    it.last = 1'b0;
    it.no_gap = text_calm;
    it.drain = 1'b0;
    char_queue.push_back(it);
  endfunction

  function automatic void add_char(logic [20:0] cp);
    logic [31:0] b;
    logic [2:0]  n;
    if (cp < 21'h80) begin
      b = {24'd0, cp[7:0]};
      n = 3'd1;
    end else if (cp < 21'h800) begin
      b = {16'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
      n = 3'd2;
    end else if (cp < 21'h10000) begin
      b = {8'd0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
      n = 3'd3;
    end else begin
      b = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12], 5'b11110, cp[20:18]};
      n = 3'd4;
    end
    add_raw(cp, b, n);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_char({13'd0, s[i]});
  endfunction

  function automatic void end_text();
    char_item_t it;
    it = char_queue.pop_back();
    it.last = 1'b1;
    char_queue.push_back(it);
  endfunction

  function automatic logic [20:0] rand_letter();
    int r;
    r = $urandom_range(0, 57);
    if (r < 26) return slsc_pkg::CP_LOWER_A + 21'(r);
    if (r < 52) return slsc_pkg::CP_UPPER_A + 21'(r - 26);
    case (r)
      52: return slsc_pkg::CP_A_RING_LC;
      53: return slsc_pkg::CP_A_UML_LC;
      54: return slsc_pkg::CP_O_UML_LC;
      55: return slsc_pkg::CP_A_RING_UC;
      56: return slsc_pkg::CP_A_UML_UC;
      default: return slsc_pkg::CP_O_UML_UC;
    endcase
  endfunction

  function automatic logic [20:0] rand_digit();
    return slsc_pkg::CP_DIGIT_0 + 21'($urandom_range(0, 9));
  endfunction

  function automatic int pick_len(int lo, int hi);
    if ($urandom_range(0, 99) < 3) return $urandom_range(120, 140);
    return $urandom_range(lo, hi);
  endfunction

  function automatic logic [20:0] rand_delim();
    case ($urandom_range(0, 6))
      0: return slsc_pkg::CP_LPAREN;
      1: return slsc_pkg::CP_RPAREN;
      2: return slsc_pkg::CP_LESS;
      3: return slsc_pkg::CP_GREATER;
      4: return slsc_pkg::CP_SEMICOLON;
      5: return slsc_pkg::CP_COMMA;
      default: return slsc_pkg::CP_COLON;
    endcase
  endfunction

  function automatic logic [20:0] rand_text_char();
    int          r;
    logic [20:0] cp;
    r = $urandom_range(0, 99);
    if (r < 10) return slsc_pkg::CP_NEWLINE;
    if (r < 20) return 21'($urandom_range(21'h80, 21'h10FFFF));
    if (r < 25) begin
      return ($urandom_range(0, 1) != 0) ? slsc_pkg::CP_PERCENT : slsc_pkg::CP_SLASH;
    end
    cp = 21'($urandom_range(21'h20, 21'h7E));
    return (cp == slsc_pkg::CP_QUOTE) ? slsc_pkg::CP_SPACE : cp;
  endfunction

  function automatic void add_noise();
    logic [20:0] cp;
    case ($urandom_range(0, 3))
      0: cp = 21'($urandom_range(0, 21'h10FFFF));
      1: cp = 21'($urandom_range(21'h100000, 21'h10FFFF));
      2: cp = 21'($urandom_range(0, 21'h7F));
      default: cp = 21'($urandom_range(21'h80, 21'hFF));
    endcase
    add_raw(cp, $urandom(), 3'($urandom_range(0, 7)));
  endfunction

  function automatic void add_piece();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      add_char(rand_letter());
      n = pick_len(0, 7);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 19))
          0: add_raw(rand_letter(), $urandom(), 3'($urandom_range(0, 7)));
          1: add_char(slsc_pkg::CP_UNDERLINE);
          2: add_char(slsc_pkg::CP_DOT);
          3, 4, 5: add_char(rand_digit());
          default: add_char(rand_letter());
        endcase
      end
    end else if (r < 35) begin
      n = pick_len(1, 6);
      for (int i = 0; i < n; i++) begin
        if (i > 0 && $urandom_range(0, 9) == 0) add_char(slsc_pkg::CP_DOT);
        add_char(rand_digit());
      end
    end else if (r < 45) begin
      add_char(slsc_pkg::CP_QUOTE);
      n = pick_len(0, 8);
      for (int i = 0; i < n; i++) add_char(rand_text_char());
      if ($urandom_range(0, 9) != 0) add_char(slsc_pkg::CP_QUOTE);
    end else if (r < 60) begin
      add_char(rand_delim());
    end else if (r < 75) begin
      case ($urandom_range(0, 3))
        0: add_char(slsc_pkg::CP_SPACE);
        1: add_char(slsc_pkg::CP_TAB);
        2: add_char(slsc_pkg::CP_RETURN);
        default: add_char(slsc_pkg::CP_NEWLINE);
      endcase
    end else if (r < 82) begin
      add_text("//");
      n = $urandom_range(0, 8);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 7) == 0) add_char(slsc_pkg::CP_QUOTE);
        else add_char(rand_text_char());
      end
      if ($urandom_range(0, 9) != 0) add_char(slsc_pkg::CP_NEWLINE);
    end else if (r < 89) begin
      add_text("/%");
      n = $urandom_range(0, 8);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 5))
          0: add_char(slsc_pkg::CP_PERCENT);
          1: add_char(slsc_pkg::CP_NEWLINE);
          2: add_char(rand_letter());
          3: add_char(slsc_pkg::CP_QUOTE);
          default: add_char(slsc_pkg::CP_SPACE);
        endcase
      end
      if ($urandom_range(0, 6) != 0) add_text("%/");
    end else if (r < 94) begin
      add_char(slsc_pkg::CP_SLASH);
    end else begin
      add_noise();
    end
  endfunction

  function automatic void add_random_text(bit hold_first);
    int start;
    int pieces;
    char_item_t it;
    start = char_queue.size();
    text_calm = ($urandom_range(0, 99) < 15);
    pieces = $urandom_range(1, 30);
    for (int i = 0; i < pieces; i++) add_piece();
    end_text();
    if (hold_first || $urandom_range(0, 99) < 20) begin
      it = char_queue[start];
      it.drain = 1'b1;
      char_queue[start] = it;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  // Character driver.
  always @(posedge clk) begin
    if (rst) begin
      chars.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (chars.valid && chars.ready) begin
        scan_char(driven.cp, driven.bytes, driven.count, driven.last);
        if (!driven.no_gap && $urandom_range(0, 99) < 30) gap_left = pick_gap();
      end
      if (!chars.valid || chars.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          chars.valid <= 1'b0;
        end else if (char_queue.size() > 0 &&
                     !(char_queue[0].drain && lexeme_expect.size() != 0)) begin
          driven = char_queue.pop_front();
          chars.valid <= 1'b1;
          chars.codepoint <= driven.cp;
          chars.utf8_bytes <= driven.bytes;
          chars.byte_count <= driven.count;
          chars.last_char <= driven.last;
        end else begin
          chars.valid <= 1'b0;
        end
      end
    end
  end

  // Lexeme monitor and checker.
  always @(posedge clk) begin
    if (rst) begin
      lexemes.ready <= 1'b0;
      stall_left = 0;
      calm_left = 0;
    end else begin
      if (lexemes.valid && lexemes.ready) begin
        seen.kind = slsc_pkg::lex_kind_t'(lexemes.lex_kind);
        seen.is_end = lexemes.is_end;
        seen.data_byte = lexemes.data_byte;
        seen.length = lexemes.lexeme_length;
        seen.truncated = lexemes.truncated;
        seen.line = lexemes.start_line;
        seen.column = lexemes.start_column;
        seen.run_last = lexemes.run_last;
        if (lexeme_expect.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t unexpected transaction: kind=%0d end=%0d byte=%02h len=%0d",
                     $realtime, seen.kind, seen.is_end, seen.data_byte, seen.length);
        end else begin
          wanted = lexeme_expect.pop_front();
          if (seen !== wanted) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"%0t mismatch: expected kind=%0d end=%0d byte=%02h len=%0d trunc=%0d",
                        " line=%0d col=%0d last=%0d, got kind=%0d end=%0d byte=%02h len=%0d",
                        " trunc=%0d line=%0d col=%0d last=%0d"},
                       $realtime, wanted.kind, wanted.is_end, wanted.data_byte, wanted.length,
                       wanted.truncated, wanted.line, wanted.column, wanted.run_last,
                       seen.kind, seen.is_end, seen.data_byte, seen.length, seen.truncated,
                       seen.line, seen.column, seen.run_last);
          end
        end
      end
      if (calm_left > 0) begin
        calm_left--;
        lexemes.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        lexemes.ready <= 1'b0;
      end else begin
        lexemes.ready <= 1'b1;
        if ($urandom_range(0, 99) < 2) calm_left = $urandom_range(50, 300);
        else if ($urandom_range(0, 99) < 20) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if ((chars.valid && chars.ready) || (lexemes.valid && lexemes.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("source_lexeme_scanner_top verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    chars.valid = 1'b0;
    chars.codepoint = '0;
    chars.utf8_bytes = '0;
    chars.byte_count = 3'd1;
    chars.last_char = 1'b0;
    lexemes.ready = 1'b0;
    mismatch_count = 0;
    text_calm = 1'b0;
    mode = slsc_pkg::SCAN_IDLE;
    line_no = 16'd1;
    col_no = 16'd1;
    lex_line = 16'd1;
    lex_col = 16'd1;
    stored = 0;
    has_dot = 1'b0;
    overflowed = 1'b0;

    // Identifier with a multibyte letter, delimiter, number ended by a second dot,
    // string holding a newline, lone slash, line and block comments, and a string
    // left open by the end of the text.
    add_char(slsc_pkg::CP_A_RING_UC);
    add_text("z_.9(1.5.\"\n\"/x//c\n/%%/;\"");
    end_text();
    add_raw(21'h10FFFF, 32'hFFFFFFFF, 3'd7);
    add_raw(21'h0, 32'h0, 3'd0);
    add_text("/%<");
    end_text();
    add_text("a/");
    end_text();

    add_random_text(1'b1);
    while (char_queue.size() < ITEM_TARGET) add_random_text(1'b0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (char_queue.size() != 0 || chars.valid) @(negedge clk);
    while (lexeme_expect.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("source_lexeme_scanner_top verification clean");
    end else begin
      $display("source_lexeme_scanner_top verification failed");
    end
    $finish;
  end

endmodule
